// ----- hdl/wasm_pkg.sv -----
// Shared types and constants for the windowed average slew meter.
package wasm_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned SUM_W = 22;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned DIV_W = SUM_W + 1;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [VAL_W-1:0] WINDOW_RESET = 16'd1600;
	localparam logic [VAL_W-1:0] DROP_RESET = 16'd20;
	localparam logic [CNT_W-1:0] CAP_RESET = 6'd40;

	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_DROP = 2'd1,
		REG_CAP = 2'd2
	} reg_idx_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_RESET = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_WB
	} back_state_t;

	typedef struct packed {
		kind_t kind;
		logic [TIME_W-1:0] now;
		logic [VAL_W-1:0] power;
		logic [VAL_W-1:0] raw;
		logic [VAL_W-1:0] ma;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] window_len;
		logic [VAL_W-1:0] drop;
		logic [CNT_W-1:0] cap;
	} cfg_t;

endpackage

// ----- hdl/windowed_average_slew_meter_unit.sv -----
// A request is queued, then popped by the back end and answered from the result
// register; a sample that closes a non-empty window first runs the serial dividers.
// Throughput: one request per cycle without a close while results are taken; a close
// holds the back end until its 23-step dividers end (three lanes run side by side).
// Reset: arst_n clears the queue, the meter state and the result valid flag, and
// restores the window, drop and cap registers to their defaults.
module windowed_average_slew_meter_unit import wasm_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input  logic sample_valid,
	output logic sample_ready,
	input  logic cmd,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [VAL_W-1:0] power_sample,
	input  logic [VAL_W-1:0] raw_current_sample,
	input  logic [VAL_W-1:0] current_ma_sample,
	output logic result_valid,
	input  logic result_ready,
	output logic [VAL_W-1:0] shown_power,
	output logic [VAL_W-1:0] shown_raw_current,
	output logic [VAL_W-1:0] shown_current_ma,
	output logic window_closed
);

	cfg_t cfg_q;
	item_t item;
	logic item_valid, item_pop, wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len <= WINDOW_RESET;
			cfg_q.drop <= DROP_RESET;
			cfg_q.cap <= CAP_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_WINDOW: cfg_q.window_len <= pwdata[VAL_W-1:0];
				REG_DROP: cfg_q.drop <= pwdata[VAL_W-1:0];
				REG_CAP: cfg_q.cap <= pwdata[CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW: prdata = DATA_W'(cfg_q.window_len);
			REG_DROP: prdata = DATA_W'(cfg_q.drop);
			REG_CAP: prdata = DATA_W'(cfg_q.cap);
			default: prdata = '0;
		endcase
	end

	wasm_front #(.Depth(QueueDepth)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.cmd(cmd),
		.now_ms(now_ms),
		.power_sample(power_sample),
		.raw_current_sample(raw_current_sample),
		.current_ma_sample(current_ma_sample),
		.item(item),
		.item_valid(item_valid),
		.item_pop(item_pop)
	);

	wasm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(item),
		.item_valid(item_valid),
		.item_pop(item_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.shown_power(shown_power),
		.shown_raw_current(shown_raw_current),
		.shown_current_ma(shown_current_ma),
		.window_closed(window_closed)
	);

endmodule

// ----- hdl/wasm_front.sv -----
// Front end: takes requests, classifies them and queues them for the back end.
module wasm_front import wasm_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  logic cmd,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [VAL_W-1:0] power_sample,
	input  logic [VAL_W-1:0] raw_current_sample,
	input  logic [VAL_W-1:0] current_ma_sample,
	output item_t item,
	output logic item_valid,
	input  logic item_pop
);

	localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned FILL_W = $clog2(Depth + 1);

	item_t mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic push, pop;
	item_t incoming;

	assign sample_ready = (fill_q != FILL_W'(Depth));
	assign item_valid = (fill_q != '0);
	assign item = mem_q[rd_ptr_q];
	assign push = sample_valid && sample_ready;
	assign pop = item_pop && item_valid;

	always_comb begin
		incoming.kind = cmd ? KIND_RESET : KIND_SAMPLE;
		incoming.now = now_ms;
		incoming.power = power_sample;
		incoming.raw = raw_current_sample;
		incoming.ma = current_ma_sample;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- hdl/wasm_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module wasm_div import wasm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic done,
	output logic [VAL_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(DIV_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	logic busy_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0] acc_q;
	logic [CNT_W-1:0] rem_q, div_q;
	logic [CNT_W:0] trial, diff;
	logic fits;

	assign trial = {rem_q, acc_q[DIV_W-1]};
	assign fits = (trial >= {1'b0, div_q});
	assign diff = trial - {1'b0, div_q};
	assign done = done_q;
	assign quotient = acc_q[VAL_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- hdl/wasm_back.sv -----
// Back end: meter state, window close with serial averages, result register.
module wasm_back import wasm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  item_t item,
	input  logic item_valid,
	output logic item_pop,
	output logic result_valid,
	input  logic result_ready,
	output logic [VAL_W-1:0] shown_power,
	output logic [VAL_W-1:0] shown_raw_current,
	output logic [VAL_W-1:0] shown_current_ma,
	output logic window_closed
);

	back_state_t state_q, state_d;

	logic has_first_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] ptot_q, rtot_q, mtot_q;
	logic [TIME_W-1:0] start_q;
	logic [VAL_W-1:0] hp_q, hr_q, hm_q;

	logic res_valid_q;
	logic [VAL_W-1:0] res_p_q, res_r_q, res_m_q;
	logic res_closed_q;

	logic out_free, first, take, close, need_div;
	logic [VAL_W-1:0] hp_a, hr_a, hm_a;
	logic [TIME_W-1:0] start_a, elapsed;
	logic [SUM_W-1:0] ptot_a, rtot_a, mtot_a;
	logic [CNT_W-1:0] cnt_a;
	logic [DIV_W-1:0] half, pdvd, rdvd, mdvd;

	logic div_start, dp_done, dr_done, dm_done, div_done;
	logic [VAL_W-1:0] qp, qr, qm, hp_slew;
	logic wb_fire;

	assign out_free = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign shown_power = res_p_q;
	assign shown_raw_current = res_r_q;
	assign shown_current_ma = res_m_q;
	assign window_closed = res_closed_q;

	always_comb begin
		first = !has_first_q;
		hp_a = first ? item.power : hp_q;
		hr_a = first ? item.raw : hr_q;
		hm_a = first ? item.ma : hm_q;
		start_a = first ? item.now : start_q;
		take = (count_q < cfg.cap);
		ptot_a = take ? ptot_q + SUM_W'(item.power) : ptot_q;
		rtot_a = take ? rtot_q + SUM_W'(item.raw) : rtot_q;
		mtot_a = take ? mtot_q + SUM_W'(item.ma) : mtot_q;
		cnt_a = take ? count_q + 1'b1 : count_q;
		elapsed = item.now - start_a;
		close = (elapsed >= TIME_W'(cfg.window_len));
		need_div = close && (cnt_a != '0);
		half = DIV_W'(cnt_a[CNT_W-1:1]);
		pdvd = DIV_W'(ptot_a) + half;
		rdvd = DIV_W'(rtot_a) + half;
		mdvd = DIV_W'(mtot_a) + half;
	end

	always_comb begin
		if ((hp_q > qp) && ((hp_q - qp) > cfg.drop)) begin
			hp_slew = hp_q - cfg.drop;
		end else begin
			hp_slew = qp;
		end
	end

	always_comb begin
		state_d = state_q;
		item_pop = 1'b0;
		div_start = 1'b0;
		wb_fire = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (item_valid && out_free) begin
					item_pop = 1'b1;
					if ((item.kind == KIND_SAMPLE) && need_div) begin
						div_start = 1'b1;
						state_d = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_WB;
				end
			end
			BK_WB: begin
				if (out_free) begin
					wb_fire = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign div_done = dp_done && dr_done && dm_done;

	wasm_div u_div_p (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(pdvd),
		.divisor(cnt_a), .done(dp_done), .quotient(qp)
	);
	wasm_div u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(rdvd),
		.divisor(cnt_a), .done(dr_done), .quotient(qr)
	);
	wasm_div u_div_m (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mdvd),
		.divisor(cnt_a), .done(dm_done), .quotient(qm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_first_q <= 1'b0;
			count_q <= '0;
			ptot_q <= '0;
			rtot_q <= '0;
			mtot_q <= '0;
			start_q <= '0;
			hp_q <= '0;
			hr_q <= '0;
			hm_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((item_pop && ((item.kind == KIND_RESET) || !need_div)) || wb_fire) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (item_pop) begin
				if (item.kind == KIND_RESET) begin
					has_first_q <= 1'b0;
					count_q <= '0;
					ptot_q <= '0;
					rtot_q <= '0;
					mtot_q <= '0;
					start_q <= item.now;
					hp_q <= '0;
					hr_q <= '0;
					hm_q <= '0;
				end else begin
					has_first_q <= 1'b1;
					hp_q <= hp_a;
					hr_q <= hr_a;
					hm_q <= hm_a;
					if (close) begin
						count_q <= '0;
						ptot_q <= '0;
						rtot_q <= '0;
						mtot_q <= '0;
						start_q <= item.now;
					end else begin
						count_q <= cnt_a;
						ptot_q <= ptot_a;
						rtot_q <= rtot_a;
						mtot_q <= mtot_a;
						start_q <= start_a;
					end
				end
			end
			if (wb_fire) begin
				hp_q <= hp_slew;
				hr_q <= qr;
				hm_q <= qm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			if (item.kind == KIND_RESET) begin
				res_p_q <= '0;
				res_r_q <= '0;
				res_m_q <= '0;
				res_closed_q <= 1'b0;
			end else if (!need_div) begin
				res_p_q <= hp_a;
				res_r_q <= hr_a;
				res_m_q <= hm_a;
				res_closed_q <= close;
			end
		end
		if (wb_fire) begin
			res_p_q <= hp_slew;
			res_r_q <= qr;
			res_m_q <= qm;
			res_closed_q <= 1'b1;
		end
	end

endmodule

// ----- hdl/wasm_checker.sv -----
// Port-level checker for the meter, bound to the top level.
module wasm_checker import wasm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic pready,
	input logic sample_valid,
	input logic sample_ready,
	input logic cmd,
	input logic [TIME_W-1:0] now_ms,
	input logic [VAL_W-1:0] power_sample,
	input logic [VAL_W-1:0] raw_current_sample,
	input logic [VAL_W-1:0] current_ma_sample,
	input logic result_valid,
	input logic result_ready,
	input logic [VAL_W-1:0] shown_power,
	input logic [VAL_W-1:0] shown_raw_current,
	input logic [VAL_W-1:0] shown_current_ma,
	input logic window_closed
);

	logic [7:0] pending_q;
	logic acc_in, acc_out;

	assign acc_in = sample_valid && sample_ready;
	assign acc_out = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 8'(acc_in) - 8'(acc_out);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(shown_power)
			&& $stable(shown_raw_current) && $stable(shown_current_ma)
			&& $stable(window_closed))
		else $error("result changed while stalled");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(cmd)
			&& $stable(now_ms) && $stable(power_sample)
			&& $stable(raw_current_sample) && $stable(current_ma_sample))
		else $error("request changed while waiting");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 8'd0)
		else $error("result without pending request");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 8'(QUEUE_DEPTH + 2))
		else $error("more requests in flight than storage");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_WINDOW
		|=> paddr[3:2] != REG_WINDOW || prdata[15:0] == $past(pwdata[15:0]))
		else $error("window length readback mismatch");

endmodule

bind windowed_average_slew_meter_unit wasm_checker u_wasm_checker (.*);
